### src/jsu_pkg.sv
`timescale 1ns / 1ps

package jsu_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_CLOSED  = 2'd1,
        KIND_UNTERM  = 2'd2,
        KIND_NOQUOTE = 2'd3
    } t_kind;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_TEXT  = 5'b00010,
        PH_ESC   = 5'b00100,
        PH_HEX   = 5'b01000,
        PH_DONE  = 5'b10000
    } t_phase;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int JOB_ITEMS   = 4;

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // Decoded control bytes
    localparam logic [7:0] BS_CODE = 8'h08;
    localparam logic [7:0] FF_CODE = 8'h0C;

    // UTF-8 limits and markers
    localparam logic [15:0] UTF_LIM1 = 16'h007F;
    localparam logic [15:0] UTF_LIM2 = 16'h07FF;
    localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF_CONT  = 8'h80;
    localparam logic [5:0]  UTF_MASK  = 6'h3F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       frame_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       run_last;
    } t_out;

    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
    } t_res;

    // All results caused by one input byte
    typedef struct packed {
        logic [2:0]                 cnt;
        t_res [JOB_ITEMS-1:0]       item;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    typedef struct packed {
        logic [1:0] cnt;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
    } t_utf8;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic t_utf8 utf8_enc(input logic [15:0] code);
        t_utf8 u;
        u = '0;
        if (code <= UTF_LIM1) begin
            u.cnt = 2'd1;
            u.b0  = code[7:0];
        end else if (code <= UTF_LIM2) begin
            u.cnt = 2'd2;
            u.b0  = UTF_LEAD2 | {3'd0, code[10:6]};
            u.b1  = UTF_CONT | {2'd0, code[5:0] & UTF_MASK};
        end else begin
            u.cnt = 2'd3;
            u.b0  = UTF_LEAD3 | {4'd0, code[15:12]};
            u.b1  = UTF_CONT | {2'd0, code[11:6] & UTF_MASK};
            u.b2  = UTF_CONT | {2'd0, code[5:0] & UTF_MASK};
        end
        return u;
    endfunction

endpackage

### src/jsu_front.sv
`timescale 1ns / 1ps

module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  jsu_pkg::t_in  i_data,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output jsu_pkg::t_job o_job
);

    jsu_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_hcnt, n_hcnt;
    logic [15:0]     r_acc, n_acc;
    logic            r_run, n_run;

    jsu_pkg::t_job   job;
    jsu_pkg::t_hex   hv;
    jsu_pkg::t_utf8  u;
    logic [15:0]     acc_new;
    logic [2:0]      hcnt_new;
    logic [7:0]      c;
    logic            last;
    logic            open;
    logic            accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign c       = i_data.in_byte;
    assign last    = i_data.frame_end;
    assign hv      = jsu_pkg::hex_digit(c);

    // Classify the byte and build its result list
    always_comb begin
        n_phase  = r_phase;
        n_hcnt   = r_hcnt;
        n_acc    = r_acc;
        n_run    = r_run;
        job      = '0;
        open     = 1'b0;
        acc_new  = r_acc;
        hcnt_new = r_hcnt + 3'd1;
        u        = jsu_pkg::utf8_enc(16'd0);
        unique case (r_phase)
            jsu_pkg::PH_START: begin
                if (c == jsu_pkg::CH_SPACE || c == jsu_pkg::CH_TAB ||
                    c == jsu_pkg::CH_CR || c == jsu_pkg::CH_LF) begin
                    if (last) begin
                        job.item[0].kind = jsu_pkg::KIND_NOQUOTE;
                        job.cnt = 3'd1;
                    end
                end else if (c == jsu_pkg::CH_QUOTE) begin
                    n_phase = jsu_pkg::PH_TEXT;
                    open    = 1'b1;
                end else begin
                    job.item[0].kind = jsu_pkg::KIND_NOQUOTE;
                    job.cnt = 3'd1;
                    n_phase = jsu_pkg::PH_DONE;
                end
            end
            jsu_pkg::PH_TEXT: begin
                if (c == jsu_pkg::CH_QUOTE) begin
                    job.item[0].kind = jsu_pkg::KIND_CLOSED;
                    job.cnt = 3'd1;
                    n_phase = jsu_pkg::PH_DONE;
                end else if (c == jsu_pkg::CH_BSL) begin
                    n_phase = jsu_pkg::PH_ESC;
                    open    = 1'b1;
                end else begin
                    job.item[0].out_byte = c;
                    job.item[0].kind     = jsu_pkg::KIND_DATA;
                    job.cnt = 3'd1;
                    open    = 1'b1;
                end
            end
            jsu_pkg::PH_ESC: begin
                open    = 1'b1;
                n_phase = jsu_pkg::PH_TEXT;
                job.item[0].kind = jsu_pkg::KIND_DATA;
                job.cnt = 3'd1;
                unique case (c)
                    jsu_pkg::CH_B: job.item[0].out_byte = jsu_pkg::BS_CODE;
                    jsu_pkg::CH_F: job.item[0].out_byte = jsu_pkg::FF_CODE;
                    jsu_pkg::CH_N: job.item[0].out_byte = jsu_pkg::CH_LF;
                    jsu_pkg::CH_R: job.item[0].out_byte = jsu_pkg::CH_CR;
                    jsu_pkg::CH_T: job.item[0].out_byte = jsu_pkg::CH_TAB;
                    jsu_pkg::CH_U: begin
                        n_phase = jsu_pkg::PH_HEX;
                        n_hcnt  = 3'd0;
                        n_acc   = 16'd0;
                        n_run   = 1'b1;
                        // A frame ending right after the escape still gives code 0
                        job.item[0].out_byte = 8'd0;
                        job.cnt = last ? 3'd1 : 3'd0;
                    end
                    default: job.item[0].out_byte = c;
                endcase
            end
            jsu_pkg::PH_HEX: begin
                open = 1'b1;
                if (r_run && hv.ok) begin
                    acc_new = {r_acc[11:0], hv.val};
                end else begin
                    n_run = 1'b0;
                end
                n_acc  = acc_new;
                n_hcnt = hcnt_new;
                if (hcnt_new >= 3'd4 || last) begin
                    u = jsu_pkg::utf8_enc(acc_new);
                    job.item[0].out_byte = u.b0;
                    job.item[1].out_byte = u.b1;
                    job.item[2].out_byte = u.b2;
                    job.item[0].kind = jsu_pkg::KIND_DATA;
                    job.item[1].kind = jsu_pkg::KIND_DATA;
                    job.item[2].kind = jsu_pkg::KIND_DATA;
                    job.cnt = {1'b0, u.cnt};
                    n_phase = jsu_pkg::PH_TEXT;
                    n_hcnt  = 3'd0;
                    n_acc   = 16'd0;
                    n_run   = 1'b1;
                end
            end
            jsu_pkg::PH_DONE: begin
                n_phase = jsu_pkg::PH_DONE;
            end
            default: begin
                n_phase = jsu_pkg::PH_DONE;
            end
        endcase

        // Close the frame: report an open string, then return to start
        if (last) begin
            if (open) begin
                job.item[job.cnt[1:0]].out_byte = 8'd0;
                job.item[job.cnt[1:0]].kind     = jsu_pkg::KIND_UNTERM;
                job.cnt = job.cnt + 3'd1;
            end
            n_phase = jsu_pkg::PH_START;
            n_hcnt  = 3'd0;
            n_acc   = 16'd0;
            n_run   = 1'b1;
        end
    end

    assign o_push = accept && (job.cnt != 3'd0);
    assign o_job  = job;

    // Advance parser state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= jsu_pkg::PH_START;
            r_hcnt  <= 3'd0;
            r_acc   <= 16'd0;
            r_run   <= 1'b1;
        end else if (accept) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_acc   <= n_acc;
            r_run   <= n_run;
        end
    end

endmodule

### src/jsu_queue.sv
`timescale 1ns / 1ps

module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output jsu_pkg::t_job o_head
);

    jsu_pkg::t_job                 r_mem [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QUEUE_AW-1:0]  r_wr, r_rd;
    logic [jsu_pkg::QUEUE_AW:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == (jsu_pkg::QUEUE_AW+1)'(jsu_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // Store the job at the write slot
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

endmodule

### src/jsu_back.sv
`timescale 1ns / 1ps

module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  jsu_pkg::t_job i_head,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output jsu_pkg::t_out o_data
);

    logic [1:0]    r_idx;
    logic          r_ov;
    jsu_pkg::t_out r_out;
    logic          adv;
    logic          load;
    logic          is_last;

    assign adv     = !r_ov || !i_stall;
    assign load    = adv && !i_empty;
    assign is_last = ({1'b0, r_idx} == (i_head.cnt - 3'd1));
    assign o_pop   = load && is_last;

    // Hold payload while stalled, load next result when free
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_byte <= i_head.item[r_idx].out_byte;
            r_out.kind     <= i_head.item[r_idx].kind;
            r_out.run_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            if (adv) begin
                r_ov <= load;
            end
            if (load) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

### src/json_string_unescaper_core.sv
// A result passes through the job queue and then the output register after its input byte
// is transferred.
// Throughput: one byte per cycle while each byte yields at most one result and the output
// is not stalled; the single output register drains one result per cycle when not stalled,
// so a \u escape giving three UTF-8 bytes holds the output for each in turn, absorbed by a four-job queue.
// Reset: synchronous, active low; parser returns to before the opening quote, queue empties.
`timescale 1ns / 1ps

module json_string_unescaper_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  jsu_pkg::t_in  i_data,
    output logic          o_stall,
    output logic          o_valid,
    output jsu_pkg::t_out o_data,
    input  logic          i_stall
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    jsu_pkg::t_job q_job;
    jsu_pkg::t_job q_head;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (q_full),
        .o_stall (o_stall),
        .o_push  (q_push),
        .o_job   (q_job)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    // Never write a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job queue written while full");

    // Queued jobs always carry at least one result
    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_empty |-> (q_head.cnt != 3'd0))
        else $error("empty job in queue");

    // A status result is always the last of its byte
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind != jsu_pkg::KIND_DATA) |-> o_data.run_last)
        else $error("status result not marked last");

    // Output is empty after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid straight after reset");

endmodule
